// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker of the keypad press qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define KPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/kpq_pkg.sv =====
// Package of the keypad press qualifier: sizes, command codes and payload types.
`timescale 1ns / 1ps

package kpq_pkg;

  localparam int BUTTON_COUNT = 6;
  localparam int COUNT_WIDTH  = 16;

  localparam int CMD_W   = 2;
  localparam int LEVEL_W = 6;
  localparam int INDEX_W = 3;
  localparam int HOLD_W  = 16;

  // Compare width wide enough for both the hold counter and the hold time.
  localparam int CMP_W = (COUNT_WIDTH > HOLD_W) ? COUNT_WIDTH : HOLD_W;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd50;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_SCAN = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [LEVEL_W-1:0] levels;
    logic [INDEX_W-1:0] button_index;
  } kpq_in_t;

  typedef struct packed {
    logic               fire;
    logic [INDEX_W-1:0] which_button;
  } kpq_out_t;

  typedef struct packed {
    logic tick;
    logic scan;
    logic level;
    logic rd;
  } kpq_cell_ctrl_t;

endpackage

// ===== rtl/core/kpq_in_stage.sv =====
// Input register of the keypad press qualifier, with stall towards the sender.
`timescale 1ns / 1ps

module kpq_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  kpq_pkg::kpq_in_t in_data_i,
  input  logic            advance_i,
  output logic            item_valid_o,
  output kpq_pkg::kpq_in_t item_o
);

  logic             valid_q;
  logic             valid_d;
  kpq_pkg::kpq_in_t data_q;

  // The held item blocks a new transfer only when it cannot move on.
  assign in_stall_o = valid_q && !advance_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

// ===== rtl/core/kpq_button_cell.sv =====
// State of one button: last level, saturating hold counter, pressed and consumed flags.
`timescale 1ns / 1ps

module kpq_button_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kpq_pkg::kpq_cell_ctrl_t         ctrl_i,
  input  logic [kpq_pkg::HOLD_W-1:0]      hold_time_i,
  output logic                            fire_o
);

  logic                            last_q;
  logic                            last_d;
  logic [kpq_pkg::COUNT_WIDTH-1:0] count_q;
  logic [kpq_pkg::COUNT_WIDTH-1:0] count_d;
  logic [kpq_pkg::COUNT_WIDTH-1:0] count_eff;
  logic                            pressed_q;
  logic                            pressed_d;
  logic                            consumed_q;
  logic                            consumed_d;
  logic                            held_long;

  // A falling edge restarts the hold time before it is compared.
  assign count_eff = last_q ? '0 : count_q;
  assign held_long = kpq_pkg::CMP_W'(count_eff) >= kpq_pkg::CMP_W'(hold_time_i);

  always_comb begin
    last_d     = last_q;
    count_d    = count_q;
    pressed_d  = pressed_q;
    consumed_d = consumed_q;
    if (ctrl_i.tick) begin
      if (count_q != '1) begin
        count_d = count_q + 1'b1;
      end
    end
    if (ctrl_i.scan) begin
      last_d = ctrl_i.level;
      if (ctrl_i.level) begin
        pressed_d  = 1'b0;
        consumed_d = 1'b0;
      end else begin
        count_d = count_eff;
        if (held_long) begin
          pressed_d = 1'b1;
        end
      end
    end
    if (ctrl_i.rd && pressed_q && !consumed_q) begin
      consumed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= 1'b0;
      count_q    <= '0;
      pressed_q  <= 1'b0;
      consumed_q <= 1'b0;
    end else begin
      last_q     <= last_d;
      count_q    <= count_d;
      pressed_q  <= pressed_d;
      consumed_q <= consumed_d;
    end
  end

  assign fire_o = pressed_q && !consumed_q;

endmodule

// ===== rtl/core/keypad_press_qualifier.sv =====
// Keypad press qualifier: a read item passes the input register and then the result
// register. One item is taken in every cycle while the input is not stalled.
// Only a read item gives a result, and the input stalls only while the result
// register is full and stalled. Reset clears every button's level, hold counter
// and flags and sets the hold time to 50 ms.
`timescale 1ns / 1ps

module keypad_press_qualifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kpq_pkg::HOLD_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  kpq_pkg::kpq_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output kpq_pkg::kpq_out_t           out_data_o
);

  logic [kpq_pkg::HOLD_W-1:0]       hold_q;
  logic                             item_valid;
  kpq_pkg::kpq_in_t                 item;
  logic                             is_read;
  logic                             out_free;
  logic                             advance;
  logic [kpq_pkg::BUTTON_COUNT-1:0] sel;
  logic [kpq_pkg::BUTTON_COUNT-1:0] fire_vec;
  logic                             out_valid_q;
  logic                             out_valid_d;
  kpq_pkg::kpq_out_t                out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= kpq_pkg::HOLD_RESET;
    end else if (cfg_we_i) begin
      hold_q <= cfg_wdata_i;
    end
  end

  kpq_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  assign is_read  = item.command == kpq_pkg::CMD_READ;
  assign out_free = !out_valid_q || !out_stall_i;
  // Ticks and scans leave no result, so only a read waits for the result register.
  assign advance  = item_valid && (!is_read || out_free);

  for (genvar k = 0; k < kpq_pkg::BUTTON_COUNT; k++) begin : g_cell
    kpq_pkg::kpq_cell_ctrl_t ctrl;
    logic                    level;

    if (k < kpq_pkg::LEVEL_W) begin : g_lvl
      assign level = item.levels[k];
    end else begin : g_low
      // Buttons above the levels field always read as low.
      assign level = 1'b0;
    end

    assign sel[k]     = int'(item.button_index) == k;
    assign ctrl.tick  = advance && (item.command == kpq_pkg::CMD_TICK);
    assign ctrl.scan  = advance && (item.command == kpq_pkg::CMD_SCAN);
    assign ctrl.level = level;
    assign ctrl.rd    = advance && is_read && sel[k];

    kpq_button_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .hold_time_i(hold_q),
      .fire_o     (fire_vec[k])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = advance && is_read;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_read) begin
      out_data_q.fire         <= |(sel & fire_vec);
      out_data_q.which_button <= item.button_index;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/kpq_checker.sv =====
// Port-level checks of the keypad press qualifier, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kpq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input kpq_pkg::kpq_in_t           in_data_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input kpq_pkg::kpq_out_t          out_data_o
);

  logic                        in_xfer;
  logic                        oor_index;
  logic                        out_wait;
  logic                        rd1_q;
  logic                        rd2_q;
  logic [kpq_pkg::INDEX_W-1:0] idx1_q;
  logic [kpq_pkg::INDEX_W-1:0] idx2_q;
  logic                        src_ok;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign oor_index = int'(out_data_o.which_button) >= kpq_pkg::BUTTON_COUNT;
  assign out_wait  = out_valid_o && out_stall_i;

  // Read transfers and their indexes, delayed through the rd1_q/idx1_q and rd2_q/idx2_q registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd1_q  <= 1'b0;
      rd2_q  <= 1'b0;
      idx1_q <= '0;
      idx2_q <= '0;
    end else begin
      rd1_q  <= in_xfer && (in_data_i.command == kpq_pkg::CMD_READ);
      rd2_q  <= rd1_q;
      idx1_q <= in_data_i.button_index;
      idx2_q <= idx1_q;
    end
  end

  assign src_ok = rd2_q && (out_data_o.which_button == idx2_q);

  // A stalled result stays in place until it is transferred.
  `KPQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_data_o))

  // The input only stalls behind a full, stalled result register.
  `KPQ_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_wait)

  // A fresh result comes from the read transfer that has reached rd2_q.
  `KPQ_ASSERT_IMP(a_result_src, clk_i, rst_ni, $rose(out_valid_o), src_ok)

  // A button that does not exist never fires.
  `KPQ_ASSERT_IMP(a_oor_quiet, clk_i, rst_ni, out_valid_o && oor_index, !out_data_o.fire)

endmodule

bind keypad_press_qualifier kpq_checker u_kpq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

// ===== sim/kpq_press_checker.sv =====
// Checker for the keypad press qualifier: tracks button state and compares read reports.
`timescale 1ns / 1ps

module kpq_press_checker
  import kpq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [HOLD_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  kpq_in_t           in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  kpq_out_t          out_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  logic [HOLD_W-1:0]      hold_time;
  logic                   level_seen [BUTTON_COUNT];
  logic [COUNT_WIDTH-1:0] held_ms    [BUTTON_COUNT];
  logic                   is_pressed [BUTTON_COUNT];
  logic                   is_reported[BUTTON_COUNT];
  kpq_out_t               pending_reports[$];
  int                     fails;

  // Advances the button state by one accepted item and queues the report a read gives.
  task automatic apply_keypad_item(input kpq_in_t item);
    logic     lvl;
    kpq_out_t rep;
    begin
      case (item.command)
        CMD_TICK: begin
          for (int k = 0; k < BUTTON_COUNT; k++) begin
            if (held_ms[k] != '1) held_ms[k] = held_ms[k] + 1'b1;
          end
        end
        CMD_SCAN: begin
          for (int k = 0; k < BUTTON_COUNT; k++) begin
            // Buttons above the levels field read as held low.
            lvl = (k < LEVEL_W) ? item.levels[k] : 1'b0;
            if (lvl) begin
              is_pressed[k]  = 1'b0;
              is_reported[k] = 1'b0;
            end else begin
              if (level_seen[k]) held_ms[k] = '0;
              if (held_ms[k] >= hold_time) is_pressed[k] = 1'b1;
            end
            level_seen[k] = lvl;
          end
        end
        CMD_READ: begin
          rep.fire         = 1'b0;
          rep.which_button = item.button_index;
          if (item.button_index < BUTTON_COUNT) begin
            if (is_pressed[item.button_index] && !is_reported[item.button_index]) begin
              is_reported[item.button_index] = 1'b1;
              rep.fire = 1'b1;
            end
          end
          pending_reports.push_back(rep);
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kpq_out_t want;
    if (!rst_ni) begin
      hold_time = HOLD_RESET;
      for (int k = 0; k < BUTTON_COUNT; k++) begin
        level_seen[k]  = 1'b0;
        held_ms[k]     = '0;
        is_pressed[k]  = 1'b0;
        is_reported[k] = 1'b0;
      end
      pending_reports.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) hold_time = cfg_wdata_i;
      // A result cannot leave in the same cycle as the item that causes it,
      // so checking the output transfer first is safe.
      if (out_valid_i && !out_stall_i) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual fire=%0b button=%0d",
                   $time, out_data_i.fire, out_data_i.which_button);
          fails++;
        end else begin
          want = pending_reports.pop_front();
          if (out_data_i.fire !== want.fire) begin
            $display("%0t: fire mismatch, expected %0b, actual %0b (button %0d)",
                     $time, want.fire, out_data_i.fire, want.which_button);
            fails++;
          end
          if (out_data_i.which_button !== want.which_button) begin
            $display("%0t: button mismatch, expected %0d, actual %0d",
                     $time, want.which_button, out_data_i.which_button);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_keypad_item(in_data_i);
      fail_count_o <= fails;
      pending_o    <= pending_reports.size();
    end
  end

endmodule

// ===== sim/keypad_press_qualifier_tb.sv =====
// Testbench top of the keypad press qualifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module keypad_press_qualifier_tb;
  import kpq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 290;
  localparam int LONG_HOLD_CYCLES = 150;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [HOLD_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  kpq_in_t           in_data_i   = '0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  kpq_out_t          out_data_o;

  int                fail_count;
  int                pending;
  logic              idle_en = 1'b1;
  int                hold_off_req = 0;
  int                hold_off_served = 0;
  int                long_left = 0;
  int                burst_left = 0;
  int                quiet_left = 0;
  int                send_quiet = 0;
  logic [LEVEL_W-1:0] scan_levels = '1;

  keypad_press_qualifier u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  kpq_press_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random stall bursts, quiet stretches and the occasional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      long_left   <= 0;
      burst_left  <= 0;
      quiet_left  <= 0;
    end else if (long_left > 0) begin
      out_stall_i <= 1'b1;
      long_left   <= long_left - 1;
    end else if (hold_off_served != hold_off_req) begin
      hold_off_served <= hold_off_served + 1;
      long_left       <= LONG_HOLD_CYCLES - 1;
      out_stall_i     <= 1'b1;
    end else if (!idle_en) begin
      out_stall_i <= 1'b0;
    end else if (burst_left > 0) begin
      out_stall_i <= 1'b1;
      burst_left  <= burst_left - 1;
    end else if (quiet_left > 0) begin
      out_stall_i <= 1'b0;
      quiet_left  <= quiet_left - 1;
    end else begin
      r = $urandom_range(0, 31);
      if (r == 0) begin
        out_stall_i <= 1'b0;
        quiet_left  <= $urandom_range(40, 200);
      end else if (r < 5) begin
        out_stall_i <= 1'b1;
        burst_left  <= $urandom_range(0, 18);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic kpq_in_t make_item(input logic [CMD_W-1:0] cmd,
                                        input logic [LEVEL_W-1:0] lv,
                                        input logic [INDEX_W-1:0] idx);
    kpq_in_t item;
    item.command      = cmd;
    item.levels       = lv;
    item.button_index = idx;
    return item;
  endfunction

  // Scan levels drift slowly so that buttons stay low long enough to qualify.
  function automatic kpq_in_t random_keypad_item();
    kpq_in_t     item;
    int unsigned r;
    item.levels       = LEVEL_W'($urandom_range(0, 63));
    item.button_index = INDEX_W'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    if (r < 4) begin
      item.command = CMD_UNUSED;
    end else if (r < 44) begin
      item.command = CMD_TICK;
    end else if (r < 74) begin
      item.command = CMD_SCAN;
      if ($urandom_range(0, 9) == 0) begin
        scan_levels = LEVEL_W'($urandom_range(0, 63));
      end else begin
        for (int k = 0; k < LEVEL_W; k++) begin
          if ($urandom_range(0, 15) == 0) scan_levels[k] = ~scan_levels[k];
        end
      end
      item.levels = scan_levels;
    end else begin
      item.command = CMD_READ;
      if ($urandom_range(0, 7) != 0) begin
        item.button_index = INDEX_W'($urandom_range(0, BUTTON_COUNT - 1));
      end
    end
    return item;
  endfunction

  task automatic send_item(input kpq_in_t item);
    begin
      if (send_quiet > 0) begin
        send_quiet--;
      end else if (idle_en && $urandom_range(0, 63) == 0) begin
        send_quiet = $urandom_range(30, 150);
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= item;
      do @(posedge clk_i); while (in_stall_o);
    end
  endtask

  // Lets every queued report drain, then gives in-flight ticks and scans time to land.
  task automatic wait_until_idle();
    begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (pending != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end
  endtask

  task automatic write_hold_time(input logic [HOLD_W-1:0] value);
    begin
      wait_until_idle();
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= value;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
    end
  endtask

  initial begin
    kpq_in_t     item;
    int          counted;
    logic [HOLD_W-1:0] hold;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero hold time: every low level qualifies at once, even at the first scan.
    write_hold_time('0);
    send_item(make_item(CMD_READ, '0, 3'd0));
    send_item(make_item(CMD_UNUSED, '1, '1));
    send_item(make_item(CMD_SCAN, '0, '0));
    send_item(make_item(CMD_READ, '1, 3'd0));
    send_item(make_item(CMD_READ, '0, 3'd0));
    send_item(make_item(CMD_READ, '0, 3'd5));
    send_item(make_item(CMD_READ, '0, 3'd6));
    send_item(make_item(CMD_READ, '0, 3'd7));
    send_item(make_item(CMD_SCAN, '1, '1));
    send_item(make_item(CMD_SCAN, '0, '0));
    send_item(make_item(CMD_READ, '0, 3'd3));
    send_item(make_item(CMD_TICK, '1, '1));

    // Largest hold time: a fresh falling edge cannot qualify within a short run.
    write_hold_time('1);
    send_item(make_item(CMD_SCAN, 6'h2A, 3'd0));
    send_item(make_item(CMD_SCAN, 6'h15, 3'd0));
    send_item(make_item(CMD_TICK, '0, '0));
    send_item(make_item(CMD_SCAN, '0, '0));
    send_item(make_item(CMD_READ, '0, 3'd1));
    send_item(make_item(CMD_READ, '0, 3'd2));

    // Small hold time: the press qualifies at the first scan after the second tick.
    write_hold_time(16'd2);
    send_item(make_item(CMD_SCAN, '1, '0));
    send_item(make_item(CMD_SCAN, '0, '0));
    send_item(make_item(CMD_TICK, '0, '0));
    send_item(make_item(CMD_SCAN, '0, '0));
    send_item(make_item(CMD_READ, '0, 3'd2));
    send_item(make_item(CMD_TICK, '0, '0));
    send_item(make_item(CMD_SCAN, '0, '0));
    send_item(make_item(CMD_READ, '0, 3'd2));
    send_item(make_item(CMD_READ, '0, 3'd4));

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       hold = 16'd1;
        1:       hold = 16'd0;
        2:       hold = 16'd3;
        3:       hold = 16'd8;
        4:       hold = HOLD_W'($urandom_range(9, 30));
        default: hold = HOLD_RESET;
      endcase
      write_hold_time(hold);
      if (p == 1 || p == 4) hold_off_req <= hold_off_req + 1;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        item = random_keypad_item();
        send_item(item);
        if (item.command != CMD_UNUSED) counted++;
      end
    end

    // Largest hold time, run without idling: a fresh falling edge does not qualify.
    idle_en <= 1'b0;
    write_hold_time('1);
    send_item(make_item(CMD_SCAN, '1, '0));
    send_item(make_item(CMD_SCAN, '0, '0));
    repeat (20) send_item(make_item(CMD_TICK, '0, '0));
    send_item(make_item(CMD_SCAN, '0, '0));
    for (int b = 0; b < BUTTON_COUNT; b++) send_item(make_item(CMD_READ, '0, INDEX_W'(b)));

    wait_until_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/kpq_pkg.sv
rtl/core/kpq_in_stage.sv
rtl/core/kpq_button_cell.sv
rtl/core/keypad_press_qualifier.sv
rtl/core/kpq_checker.sv
sim/kpq_press_checker.sv
sim/keypad_press_qualifier_tb.sv
